@@ rtl/gshb_pkg.sv @@
// Shared types, constants and helpers for the symbol hash table builder.
package gshb_pkg;

    // Table sizes and widths
    localparam int MAX_SYMBOLS = 1024;
    localparam int MAX_BUCKETS = 257;
    localparam int MAX_BLOOM   = 16;
    localparam int SYM_W  = 11;   // symbol count, 0..1024
    localparam int IDX_W  = 10;   // symbol table address
    localparam int BKT_W  = 9;    // bucket index and bucket count
    localparam int BLM_W  = 5;    // bloom word count, 1..16
    localparam int WIDX_W = 4;    // bloom word address
    localparam int OUT_W  = 89;   // packed result payload

    localparam logic [31:0] HASH_SEED = 32'd5381;

    // Input function codes
    localparam logic [2:0] FN_BYTE      = 3'd0;
    localparam logic [2:0] FN_BUILD     = 3'd1;
    localparam logic [2:0] FN_RD_BLOOM  = 3'd2;
    localparam logic [2:0] FN_RD_BUCKET = 3'd3;
    localparam logic [2:0] FN_RD_CHAIN  = 3'd4;
    localparam logic [2:0] FN_RD_ORDER  = 3'd5;

    // Result status codes
    localparam logic [1:0] RS_BUILD_DONE = 2'd0;
    localparam logic [1:0] RS_READ_DATA  = 2'd1;
    localparam logic [1:0] RS_RANGE      = 2'd2;
    localparam logic [1:0] RS_BUILD_OVF  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_CLR, S_CNT_RD, S_CNT_DIV, S_CNT_WAIT, S_CNT_INC,
        S_PFX_RD, S_PFX_WR, S_SC_RD, S_SC_SLOT, S_SC_WR,
        S_FIN_RD, S_FIN_H, S_FIN_WR, S_FIN_END, S_READ
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_INIT, OP_CLR, OP_CNT_RD, OP_CNT_DIV, OP_CNT_WAIT, OP_CNT_INC,
        OP_PFX_RD, OP_PFX_WR, OP_SC_RD, OP_SC_SLOT, OP_SC_WR,
        OP_FIN_RD, OP_FIN_H, OP_FIN_WR, OP_FIN_END, OP_READ
    } op_t;

    typedef struct packed {
        op_t  op;
        logic take;   // input item accepted this cycle
    } dp_cmd_t;

    typedef struct packed {
        logic i_done;     // symbol counter reached the build count
        logic b_done;     // bucket counter reached the bucket count
        logic clr_last;   // last bucket entry being cleared
        logic div_done;   // remainder ready
        logic out_busy;   // result register full and not taken
    } dp_stat_t;

    // Smallest power of two not below count/64 rounded down, at least one
    function automatic logic [BLM_W-1:0] bloom_words_for(input logic [SYM_W-1:0] cnt);
        logic [BLM_W-1:0] q;
        logic [BLM_W-1:0] p;
        q = cnt[SYM_W-1:6];
        p = BLM_W'(1);
        for (int k = 0; k < 4; k++) begin
            if (p < q) begin
                p = {p[BLM_W-2:0], 1'b0};
            end
        end
        return p;
    endfunction

endpackage

@@ rtl/gshb_ram.sv @@
// Generic single-port-write, registered-read RAM.
module gshb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/gshb_rem.sv @@
// Bit-serial remainder unit: 32-bit hash modulo the bucket count.
module gshb_rem (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [31:0]                dividend,
    input  logic [gshb_pkg::BKT_W-1:0] divisor,
    output logic                       done,
    output logic [gshb_pkg::BKT_W-1:0] rem
);
    import gshb_pkg::*;

    logic [31:0]      quo_reg;
    logic [BKT_W-1:0] rem_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [BKT_W:0]   trial;

    // One restoring step per cycle
    assign trial = {rem_reg, quo_reg[31]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_reg <= BKT_W'(trial - {1'b0, divisor});
            end else begin
                rem_reg <= trial[BKT_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("remainder done held for two cycles");
endmodule

@@ rtl/gshb_dp.sv @@
// Datapath: hashing, symbol stores, build passes, tables and result register.
module gshb_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  gshb_pkg::dp_cmd_t           cmd,
    output gshb_pkg::dp_stat_t          stat,
    input  logic [2:0]                  in_func,
    input  logic [7:0]                  in_byte,
    input  logic                        in_end,
    input  logic [gshb_pkg::IDX_W-1:0]  in_idx,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [1:0]                  out_status,
    output logic [gshb_pkg::OUT_W-1:0]  out_data
);
    import gshb_pkg::*;

    logic [31:0]       hash_reg;
    logic [SYM_W-1:0]  total_reg;
    logic              ovf_reg;
    logic [2:0]        func_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SYM_W-1:0]  i_reg;
    logic [BKT_W-1:0]  b_reg;
    logic [SYM_W-1:0]  run_reg;
    logic [SYM_W-1:0]  count_reg;
    logic [BKT_W-1:0]  nb_reg;
    logic [BLM_W-1:0]  nbl_reg;
    logic [SYM_W-1:0]  built_cnt_reg;
    logic [BKT_W-1:0]  built_nb_reg;
    logic [BLM_W-1:0]  built_nbl_reg;
    logic              built_once_reg;
    logic [31:0]       prev_h_reg;
    logic [BKT_W-1:0]  prev_b_reg;
    logic [63:0]       bloom_reg [MAX_BLOOM];
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [31:0]       hash_next;
    logic              div_done;
    logic [BKT_W-1:0]  div_rem;
    logic              first_in_bkt;
    logic [WIDX_W-1:0] widx;
    logic              load_out;

    // RAM ports
    logic              hs_we;
    logic [IDX_W-1:0]  hs_raddr;
    logic [31:0]       hs_rdata;
    logic              bk_we;
    logic [IDX_W-1:0]  bk_raddr;
    logic [BKT_W-1:0]  bk_rdata;
    logic              sl_we;
    logic [BKT_W-1:0]  sl_waddr, sl_raddr;
    logic [SYM_W-1:0]  sl_wdata, sl_rdata;
    logic              od_we;
    logic [IDX_W-1:0]  od_raddr, od_rdata;
    logic              ch_we;
    logic [IDX_W-1:0]  ch_waddr;
    logic [31:0]       ch_wdata, ch_rdata;
    logic              hd_we;
    logic [BKT_W-1:0]  hd_waddr;
    logic [SYM_W-1:0]  hd_wdata, hd_rdata;

    // Read result
    logic              rd_ok;
    logic [63:0]       rd_value;

    assign hash_next = {hash_reg[26:0], 5'd0} + hash_reg + {24'd0, in_byte};

    // Status to the controller
    assign stat.i_done   = (i_reg == count_reg);
    assign stat.b_done   = (b_reg == nb_reg);
    assign stat.clr_last = (i_reg[BKT_W-1:0] == BKT_W'(nb_reg - BKT_W'(1)));
    assign stat.div_done = div_done;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign first_in_bkt = (i_reg == '0) || (bk_rdata != prev_b_reg);
    assign widx = hs_rdata[9:6] & WIDX_W'(nbl_reg - BLM_W'(1));
    assign load_out = (cmd.op == OP_FIN_END) || (cmd.op == OP_READ);

    gshb_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == OP_CNT_DIV),
        .dividend (hs_rdata),
        .divisor  (nb_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Hash store: written on each name end while the store is not full
    assign hs_we    = cmd.take && (in_func == FN_BYTE) && in_end
                      && (total_reg < SYM_W'(MAX_SYMBOLS));
    assign hs_raddr = (cmd.op == OP_FIN_H) ? od_rdata : i_reg[IDX_W-1:0];

    gshb_ram #(.WIDTH(32), .DEPTH(MAX_SYMBOLS)) u_hash (
        .aclk(aclk), .we(hs_we), .waddr(total_reg[IDX_W-1:0]), .wdata(hash_next),
        .raddr(hs_raddr), .rdata(hs_rdata)
    );

    // Bucket of each symbol, from the count pass
    assign bk_we    = (cmd.op == OP_CNT_WAIT) && div_done;
    assign bk_raddr = (cmd.op == OP_FIN_H) ? od_rdata : i_reg[IDX_W-1:0];

    gshb_ram #(.WIDTH(BKT_W), .DEPTH(MAX_SYMBOLS)) u_bkt (
        .aclk(aclk), .we(bk_we), .waddr(i_reg[IDX_W-1:0]), .wdata(div_rem),
        .raddr(bk_raddr), .rdata(bk_rdata)
    );

    // Per-bucket counts, then running slot bases
    always_comb begin
        sl_we    = 1'b0;
        sl_waddr = b_reg;
        sl_wdata = sl_rdata + SYM_W'(1);
        unique case (cmd.op)
            OP_CLR: begin
                sl_we    = 1'b1;
                sl_waddr = i_reg[BKT_W-1:0];
                sl_wdata = '0;
            end
            OP_CNT_INC, OP_SC_WR: sl_we = 1'b1;
            OP_PFX_WR: begin
                sl_we    = 1'b1;
                sl_wdata = run_reg;
            end
            default: sl_we = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cmd.op)
            OP_CNT_WAIT: sl_raddr = div_rem;
            OP_SC_SLOT:  sl_raddr = bk_rdata;
            default:     sl_raddr = b_reg;
        endcase
    end

    gshb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_BUCKETS)) u_slot (
        .aclk(aclk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
        .raddr(sl_raddr), .rdata(sl_rdata)
    );

    // Sorted order
    assign od_we    = (cmd.op == OP_SC_WR);
    assign od_raddr = (cmd.op == OP_FIN_RD) ? i_reg[IDX_W-1:0] : in_idx;

    gshb_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SYMBOLS)) u_order (
        .aclk(aclk), .we(od_we), .waddr(sl_rdata[IDX_W-1:0]), .wdata(i_reg[IDX_W-1:0]),
        .raddr(od_raddr), .rdata(od_rdata)
    );

    // Chain words: each is written once the next symbol's bucket is known, the last at the end of the build
    always_comb begin
        ch_we    = 1'b0;
        ch_waddr = IDX_W'(i_reg - SYM_W'(1));
        ch_wdata = {prev_h_reg[31:1], bk_rdata != prev_b_reg};
        if (cmd.op == OP_FIN_WR) begin
            ch_we = (i_reg != '0);
        end else if (cmd.op == OP_FIN_END) begin
            ch_we    = (count_reg != '0);
            ch_waddr = IDX_W'(count_reg - SYM_W'(1));
            ch_wdata = {prev_h_reg[31:1], 1'b1};
        end
    end

    gshb_ram #(.WIDTH(32), .DEPTH(MAX_SYMBOLS)) u_chain (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(in_idx), .rdata(ch_rdata)
    );

    // Bucket heads
    always_comb begin
        hd_we    = 1'b0;
        hd_waddr = i_reg[BKT_W-1:0];
        hd_wdata = '0;
        if (cmd.op == OP_CLR) begin
            hd_we = 1'b1;
        end else if (cmd.op == OP_FIN_WR) begin
            hd_we    = first_in_bkt;
            hd_waddr = bk_rdata;
            hd_wdata = i_reg + SYM_W'(1);
        end
    end

    gshb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_BUCKETS)) u_head (
        .aclk(aclk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(in_idx[BKT_W-1:0]), .rdata(hd_rdata)
    );

    // Range check and table select for reads
    always_comb begin
        unique case (func_reg)
            FN_RD_BLOOM: begin
                rd_ok    = (idx_reg < IDX_W'(built_nbl_reg));
                rd_value = bloom_reg[idx_reg[WIDX_W-1:0]];
            end
            FN_RD_BUCKET: begin
                rd_ok    = (idx_reg < IDX_W'(built_nb_reg));
                rd_value = {53'd0, hd_rdata};
            end
            FN_RD_CHAIN: begin
                rd_ok    = ({1'b0, idx_reg} < built_cnt_reg);
                rd_value = {32'd0, ch_rdata};
            end
            default: begin
                rd_ok    = ({1'b0, idx_reg} < built_cnt_reg);
                rd_value = {54'd0, od_rdata};
            end
        endcase
        if (!built_once_reg || !rd_ok) begin
            rd_value = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg       <= HASH_SEED;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            built_cnt_reg  <= '0;
            built_nb_reg   <= BKT_W'(1);
            built_nbl_reg  <= BLM_W'(1);
            built_once_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.take && (in_func == FN_BYTE)) begin
                if (in_end) begin
                    hash_reg <= HASH_SEED;
                    if (total_reg < SYM_W'(MAX_SYMBOLS)) begin
                        total_reg <= total_reg + SYM_W'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end else begin
                    hash_reg <= hash_next;
                end
            end
            if (cmd.op == OP_FIN_END) begin
                built_cnt_reg  <= count_reg;
                built_nb_reg   <= nb_reg;
                built_nbl_reg  <= nbl_reg;
                built_once_reg <= 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Build counters, bloom words and result payload
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            func_reg <= in_func;
            idx_reg  <= in_idx;
        end
        unique case (cmd.op)
            OP_INIT: begin
                i_reg     <= '0;
                count_reg <= total_reg;
                nb_reg    <= BKT_W'(total_reg[SYM_W-1:2]) + BKT_W'(1);
                nbl_reg   <= bloom_words_for(total_reg);
                for (int k = 0; k < MAX_BLOOM; k++) begin
                    bloom_reg[k] <= '0;
                end
            end
            OP_CLR: i_reg <= stat.clr_last ? '0 : i_reg + SYM_W'(1);
            OP_CNT_RD: begin
                if (stat.i_done) begin
                    i_reg   <= '0;
                    b_reg   <= '0;
                    run_reg <= '0;
                end
            end
            OP_CNT_WAIT: begin
                if (div_done) begin
                    b_reg <= div_rem;
                end
            end
            OP_CNT_INC, OP_SC_WR: i_reg <= i_reg + SYM_W'(1);
            OP_PFX_WR: begin
                run_reg <= run_reg + sl_rdata;
                b_reg   <= b_reg + BKT_W'(1);
            end
            OP_SC_RD: begin
                if (stat.i_done) begin
                    i_reg <= '0;
                end
            end
            OP_SC_SLOT: b_reg <= bk_rdata;
            OP_FIN_WR: begin
                bloom_reg[widx] <= bloom_reg[widx] | (64'd1 << hs_rdata[5:0])
                                   | (64'd1 << hs_rdata[11:6]);
                prev_h_reg <= hs_rdata;
                prev_b_reg <= bk_rdata;
                i_reg      <= i_reg + SYM_W'(1);
            end
            OP_FIN_END: begin
                out_status_reg <= ovf_reg ? RS_BUILD_OVF : RS_BUILD_DONE;
                out_data_reg   <= {count_reg, nbl_reg, nb_reg, 64'd0};
            end
            OP_READ: begin
                out_status_reg <= rd_ok ? RS_READ_DATA : RS_RANGE;
                out_data_reg   <= {built_cnt_reg, built_nbl_reg, built_nb_reg, rd_value};
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;

    out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");
    head_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FIN_WR) |-> (bk_rdata < nb_reg))
        else $error("bucket index beyond bucket count");
    slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_SC_WR) |-> (sl_rdata < count_reg))
        else $error("sorted slot beyond symbol count");
endmodule

@@ rtl/gshb_ctrl.sv @@
// Controller: sequences item handling and the build passes.
module gshb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [2:0]          in_func,
    output logic                in_ready,
    input  gshb_pkg::dp_stat_t  stat,
    output gshb_pkg::dp_cmd_t   cmd
);
    import gshb_pkg::*;

    state_t state_reg, state_next;
    logic   take;

    assign in_ready = (state_reg == S_IDLE) && !stat.out_busy;
    assign take     = in_valid && in_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command
    always_comb begin
        state_next = state_reg;
        cmd.take   = take;
        cmd.op     = OP_IDLE;
        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    if (in_func == FN_BUILD) begin
                        state_next = S_INIT;
                    end else if ((in_func == FN_RD_BLOOM) || (in_func == FN_RD_BUCKET)
                                 || (in_func == FN_RD_CHAIN) || (in_func == FN_RD_ORDER)) begin
                        state_next = S_READ;
                    end
                end
            end
            S_INIT: begin
                cmd.op     = OP_INIT;
                state_next = S_CLR;
            end
            S_CLR: begin
                cmd.op = OP_CLR;
                if (stat.clr_last) begin
                    state_next = S_CNT_RD;
                end
            end
            S_CNT_RD: begin
                cmd.op     = OP_CNT_RD;
                state_next = stat.i_done ? S_PFX_RD : S_CNT_DIV;
            end
            S_CNT_DIV: begin
                cmd.op     = OP_CNT_DIV;
                state_next = S_CNT_WAIT;
            end
            S_CNT_WAIT: begin
                cmd.op = OP_CNT_WAIT;
                if (stat.div_done) begin
                    state_next = S_CNT_INC;
                end
            end
            S_CNT_INC: begin
                cmd.op     = OP_CNT_INC;
                state_next = S_CNT_RD;
            end
            S_PFX_RD: begin
                cmd.op     = OP_PFX_RD;
                state_next = stat.b_done ? S_SC_RD : S_PFX_WR;
            end
            S_PFX_WR: begin
                cmd.op     = OP_PFX_WR;
                state_next = S_PFX_RD;
            end
            S_SC_RD: begin
                cmd.op     = OP_SC_RD;
                state_next = stat.i_done ? S_FIN_RD : S_SC_SLOT;
            end
            S_SC_SLOT: begin
                cmd.op     = OP_SC_SLOT;
                state_next = S_SC_WR;
            end
            S_SC_WR: begin
                cmd.op     = OP_SC_WR;
                state_next = S_SC_RD;
            end
            S_FIN_RD: begin
                cmd.op     = OP_FIN_RD;
                state_next = stat.i_done ? S_FIN_END : S_FIN_H;
            end
            S_FIN_H: begin
                cmd.op     = OP_FIN_H;
                state_next = S_FIN_WR;
            end
            S_FIN_WR: begin
                cmd.op     = OP_FIN_WR;
                state_next = S_FIN_RD;
            end
            S_FIN_END: begin
                cmd.op     = OP_FIN_END;
                state_next = S_IDLE;
            end
            S_READ: begin
                cmd.op     = OP_READ;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    accept_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |-> (state_reg == S_IDLE))
        else $error("item accepted outside idle");
    wait_to_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CNT_WAIT && stat.div_done) |=> (state_reg == S_CNT_INC))
        else $error("count pass lost a remainder");
endmodule

@@ rtl/gnu_symbol_hash_table_builder_top.sv @@
// Top level of the symbol hash table builder.
// Input channel s_axis_*: one item per handshake. s_axis_tuser carries the
// function (name byte, build, read bloom/bucket/chain/order), s_axis_tlast
// closes a name, s_axis_tdata carries the name byte and the table index.
// Result channel m_axis_*: build and read items give one result each;
// name bytes and unused function codes give none.
// A name byte is folded into the running hash when accepted. A read passes
// through the read state, which loads the result register. A build runs the
// clear, count, prefix, scatter and finish passes, paced by the bit-serial
// remainder unit used once per symbol and by table RAMs walked one entry per step.
// One item is worked on at a time; the next is taken when the block is idle
// and its result register is empty or being taken.
// Reset clears the running hash, symbol count, overflow flag and last-build
// summary; the tables read as zero until the first build.
// If the receiver stalls, the result waits in the output register and no new
// item is accepted until it is taken.
module gnu_symbol_hash_table_builder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] name_byte, [17:8] table_index
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    input  logic        s_axis_tlast,   // name_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [63:0] read_value, [72:64] bucket_total,
                                        // [77:73] bloom_total, [88:78] symbols_held
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import gshb_pkg::*;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [OUT_W-1:0] out_data;

    gshb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gshb_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_axis_tuser),
        .in_byte    (s_axis_tdata[7:0]),
        .in_end     (s_axis_tlast),
        .in_idx     (s_axis_tdata[17:8]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_data   (out_data)
    );

    // Pad the payload to whole bytes
    assign m_axis_tdata = {7'd0, out_data};
endmodule
